### hw/rtl/tbpd_pkg.sv
// Package with the field widths, register indexes and reset values of the touch detector.
`timescale 1ns / 1ps

package tbpd_pkg;

   // Field and state widths.
   localparam int SAMPLE_W   = 16;
   localparam int FRAC_W     = 16;
   localparam int BASE_W     = 32;
   localparam int DEV_W      = 17;
   localparam int SUM_OUT_W  = 21;
   localparam int THR_W      = 16;
   localparam int LIMIT_W    = 16;
   localparam int ALPHA_W    = 4;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTLIER_LIMIT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_SHIFT     = 2'd2;

   // Register reset values.
   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 16'd5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 16'd100;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 4'd10;

   // Reported sum range.
   localparam int SUM_OUT_MAX = 1048575;
   localparam int SUM_OUT_MIN = -1048576;

endpackage

### hw/rtl/tbpd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module tbpd_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 10
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tbpd_track.sv
// Baseline tracking step: moves the Q16.16 baseline toward a sample and gives the deviation.
`timescale 1ns / 1ps

module tbpd_track (
   input  logic [tbpd_pkg::BASE_W-1:0]        baseline,
   input  logic [tbpd_pkg::SAMPLE_W-1:0]      sample,
   input  logic [tbpd_pkg::ALPHA_W-1:0]       alpha_shift,
   output logic [tbpd_pkg::BASE_W-1:0]        baseline_next,
   output logic signed [tbpd_pkg::DEV_W-1:0]  deviation
);
   import tbpd_pkg::*;

   logic signed [BASE_W:0] target;
   logic signed [BASE_W:0] base_ext;
   logic signed [BASE_W:0] delta;
   logic signed [BASE_W:0] step;
   logic signed [BASE_W:0] moved;
   logic signed [BASE_W:0] residue;

   // The arithmetic shift floors, so the new baseline never passes the sample.
   always_comb begin
      target        = $signed({1'b0, sample, {FRAC_W{1'b0}}});
      base_ext      = $signed({1'b0, baseline});
      delta         = target - base_ext;
      step          = delta >>> alpha_shift;
      moved         = base_ext + step;
      baseline_next = moved[BASE_W-1:0];
      // Sample minus new baseline, floored to an integer by dropping the fraction.
      residue       = delta - step;
      deviation     = residue[BASE_W:FRAC_W];
   end

endmodule

### hw/rtl/touch_button_press_detector_top.sv
// Top level of the touch button press detector with baseline tracking.
`timescale 1ns / 1ps

// Takes one touch sample per item and returns one result per item, in order. An item
// is taken into an input register, processed by the baseline, window and threshold
// logic, and held in a result register; a new item can be accepted every cycle while
// the result side does not stall. The window of the last WINDOW deviations lives in
// a small RAM whose registered read is prefetched at the slot the next item will use;
// a running sum replaces a pass over the window. Window entries not yet written since
// reset read as zero through per-entry valid bits, so no clearing pass is needed.
// The first item after reset only loads the baseline and the previous sample.
// Configuration writes are always ready and must be made while idle.
module touch_button_press_detector_top #(
   parameter int WINDOW = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Sample channel.
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [tbpd_pkg::SAMPLE_W-1:0]          req_touch_sample,
   // Result channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_pressed,
   output logic                                   rsp_press_edge,
   output logic                                   rsp_sample_rejected,
   output logic signed [tbpd_pkg::SUM_OUT_W-1:0]  rsp_window_sum,
   // Configuration write channel.
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tbpd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [tbpd_pkg::CSR_DATA_W-1:0]        csr_data
);
   import tbpd_pkg::*;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W  = $clog2(WINDOW * 65535 + 1) + 1;
   localparam int EXT_W  = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
   localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(SUM_OUT_MAX);
   localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(SUM_OUT_MIN);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

   // Configuration registers.
   logic [THR_W-1:0]   thr_ff,   thr_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [ALPHA_W-1:0] alpha_ff, alpha_in;

   // Input register.
   logic                in_valid_ff, in_valid_in;
   logic [SAMPLE_W-1:0] in_sample_ff, in_sample_in;

   // Detector state.
   logic                     primed_ff, primed_in;
   logic [SAMPLE_W-1:0]      prev_ff, prev_in;
   logic [BASE_W-1:0]        base_ff, base_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic                     pressed_ff, pressed_in;
   logic [WINDOW-1:0]        valid_ff, valid_in;

   // Window read prefetch and bypass.
   logic                     rd_valid_ff, rd_valid_in;
   logic                     byp_hit_ff, byp_hit_in;
   logic [DEV_W-1:0]         byp_data_ff;
   logic [DEV_W-1:0]         ram_rd_data;
   logic signed [DEV_W-1:0]  old_dev;

   // Result register.
   logic                        out_valid_ff, out_valid_in;
   logic                        out_pressed_ff, out_pressed_in;
   logic                        out_edge_ff, out_edge_in;
   logic                        out_rej_ff, out_rej_in;
   logic signed [SUM_OUT_W-1:0] out_sum_ff, out_sum_in;

   // Datapath.
   logic                     fire;
   logic                     accept;
   logic [SAMPLE_W-1:0]      jump_size;
   logic                     rejected;
   logic                     update;
   logic [BASE_W-1:0]        base_step;
   logic signed [DEV_W-1:0]  dev;
   logic signed [SUM_W-1:0]  sum_upd;
   logic signed [EXT_W-1:0]  sum_ext;

   // Handshakes.
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Configuration writes; unknown indexes are ignored.
   always_comb begin
      thr_in   = thr_ff;
      limit_in = limit_ff;
      alpha_in = alpha_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PRESS_THRESHOLD: thr_in   = csr_data[THR_W-1:0];
            CSR_OUTLIER_LIMIT:   limit_in = csr_data[LIMIT_W-1:0];
            CSR_ALPHA_SHIFT:     alpha_in = csr_data[ALPHA_W-1:0];
            default:             ;
         endcase
      end
   end

   // Input register loads whenever it is empty or draining.
   always_comb begin
      in_valid_in  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      in_sample_in = accept ? req_touch_sample : in_sample_ff;
   end

   tbpd_track u_track (
      .baseline      (base_ff),
      .sample        (in_sample_ff),
      .alpha_shift   (alpha_ff),
      .baseline_next (base_step),
      .deviation     (dev)
   );

   // Old window entry at the current slot; unwritten entries read as zero.
   assign old_dev = !rd_valid_ff ? '0 : $signed(byp_hit_ff ? byp_data_ff : ram_rd_data);

   // Outlier check, window update and threshold.
   always_comb begin
      jump_size = (in_sample_ff >= prev_ff) ? in_sample_ff - prev_ff : prev_ff - in_sample_ff;
      rejected  = primed_ff && (jump_size >= limit_ff);
      update    = fire && primed_ff && !rejected;
      sum_upd   = sum_ff + SUM_W'(dev) - SUM_W'(old_dev);

      primed_in  = primed_ff;
      prev_in    = prev_ff;
      base_in    = base_ff;
      slot_in    = slot_ff;
      sum_in     = sum_ff;
      pressed_in = pressed_ff;
      valid_in   = valid_ff;

      if (fire) begin
         primed_in = 1'b1;
         prev_in   = in_sample_ff;
         if (!primed_ff) begin
            base_in = {in_sample_ff, {FRAC_W{1'b0}}};
         end
      end
      if (update) begin
         base_in           = base_step;
         sum_in            = sum_upd;
         pressed_in        = sum_upd > $signed(SUM_W'(thr_ff));
         slot_in           = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);
         valid_in[slot_ff] = 1'b1;
      end
   end

   tbpd_ram #(
      .WIDTH (DEV_W),
      .DEPTH (WINDOW)
   ) u_window (
      .clock   (clock),
      .wr_en   (update),
      .wr_addr (slot_ff),
      .wr_data (dev),
      .rd_addr (slot_in),
      .rd_data (ram_rd_data)
   );

   // Prefetch bookkeeping: a write to the slot being fetched is forwarded.
   always_comb begin
      byp_hit_in  = update && (slot_ff == slot_in);
      rd_valid_in = valid_ff[slot_in] || byp_hit_in;
   end

   // Result fields, with the reported sum saturated to its port range.
   always_comb begin
      sum_ext        = EXT_W'(sum_in);
      out_valid_in   = fire ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
      out_pressed_in = fire ? pressed_in : out_pressed_ff;
      out_edge_in    = fire ? (pressed_in && !pressed_ff) : out_edge_ff;
      out_rej_in     = fire ? rejected : out_rej_ff;
      out_sum_in     = out_sum_ff;
      if (fire) begin
         if (sum_ext > SAT_HI) begin
            out_sum_in = SAT_HI[SUM_OUT_W-1:0];
         end else if (sum_ext < SAT_LO) begin
            out_sum_in = SAT_LO[SUM_OUT_W-1:0];
         end else begin
            out_sum_in = sum_ext[SUM_OUT_W-1:0];
         end
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THRESHOLD_RESET;
         limit_ff     <= LIMIT_RESET;
         alpha_ff     <= ALPHA_RESET;
         in_valid_ff  <= 1'b0;
         primed_ff    <= 1'b0;
         slot_ff      <= '0;
         sum_ff       <= '0;
         pressed_ff   <= 1'b0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         byp_hit_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         limit_ff     <= limit_in;
         alpha_ff     <= alpha_in;
         in_valid_ff  <= in_valid_in;
         primed_ff    <= primed_in;
         slot_ff      <= slot_in;
         sum_ff       <= sum_in;
         pressed_ff   <= pressed_in;
         valid_ff     <= valid_in;
         rd_valid_ff  <= rd_valid_in;
         byp_hit_ff   <= byp_hit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_sample_ff   <= in_sample_in;
      prev_ff        <= prev_in;
      base_ff        <= base_in;
      byp_data_ff    <= dev;
      out_pressed_ff <= out_pressed_in;
      out_edge_ff    <= out_edge_in;
      out_rej_ff     <= out_rej_in;
      out_sum_ff     <= out_sum_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_pressed         = out_pressed_ff;
   assign rsp_press_edge      = out_edge_ff;
   assign rsp_sample_rejected = out_rej_ff;
   assign rsp_window_sum      = out_sum_ff;

endmodule

### sim/touch_button_press_detector_top_test.sv
// Testbench for the touch button press detector: directed and random samples, scoreboard checked.
`timescale 1ns / 1ps

module touch_button_press_detector_top_test;
   import tbpd_pkg::*;

   localparam int WINDOW_LEN  = 10;
   localparam int QUIET_LIMIT = 500;
   localparam int HOLD_CYCLES = 40;
   localparam int MAX_REPORTS = 10;

   // Index that maps to no register; writes to it must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   // One result item as the block reports it.
   typedef struct packed {
      logic                        pressed;
      logic                        press_edge;
      logic                        sample_rejected;
      logic signed [SUM_OUT_W-1:0] window_sum;
   } press_result_type;

   // Tracks the detector state, predicts each result and checks what comes out.
   class press_scoreboard;
      logic [THR_W-1:0]    threshold;
      logic [LIMIT_W-1:0]  jump_limit;
      logic [ALPHA_W-1:0]  smoothing;
      bit                  primed;
      logic [SAMPLE_W-1:0] last_sample;
      logic [BASE_W-1:0]   baseline;
      int                  deviations[WINDOW_LEN];
      int                  slot;
      int                  sum;
      bit                  pressed_now;
      bit                  pressed_prev;
      press_result_type    expected_q[$];
      int                  mismatches;

      function new();
         threshold    = THRESHOLD_RESET;
         jump_limit   = LIMIT_RESET;
         smoothing    = ALPHA_RESET;
         primed       = 0;
         last_sample  = '0;
         baseline     = '0;
         slot         = 0;
         sum          = 0;
         pressed_now  = 0;
         pressed_prev = 0;
         mismatches   = 0;
         foreach (deviations[i]) deviations[i] = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_PRESS_THRESHOLD: threshold = data[THR_W-1:0];
            CSR_OUTLIER_LIMIT: jump_limit = data[LIMIT_W-1:0];
            CSR_ALPHA_SHIFT: smoothing = data[ALPHA_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Advance the detector by one accepted sample and queue the result it must give.
      function void note_sample(logic [SAMPLE_W-1:0] s);
         longint              target;
         longint              moved;
         int                  dev;
         int                  idx;
         int                  shown;
         logic [SAMPLE_W-1:0] jump_size;
         press_result_type    r;
         r.sample_rejected = 0;
         if (!primed) begin
            // The first sample only loads the baseline and the previous reading.
            baseline    = {s, {FRAC_W{1'b0}}};
            last_sample = s;
            primed      = 1;
         end else begin
            jump_size = (s >= last_sample) ? s - last_sample : last_sample - s;
            if (jump_size >= jump_limit) begin
               r.sample_rejected = 1;
            end else begin
               // Baseline steps toward the sample; the arithmetic shift floors.
               target   = longint'(s) <<< FRAC_W;
               moved    = longint'(baseline) + ((target - longint'(baseline)) >>> smoothing);
               baseline = moved[BASE_W-1:0];
               dev      = int'((target - longint'(baseline)) >>> FRAC_W);
               idx      = (slot < WINDOW_LEN) ? slot : 0;
               sum      = sum + dev - deviations[idx];
               deviations[idx] = dev;
               slot        = (idx + 1) % WINDOW_LEN;
               pressed_now = longint'(sum) > longint'(threshold);
            end
            last_sample = s;
         end
         r.pressed    = pressed_now;
         r.press_edge = pressed_now && !pressed_prev;
         pressed_prev = pressed_now;
         // The reported sum saturates; the comparison above used the exact one.
         shown = sum;
         if (shown > SUM_OUT_MAX) shown = SUM_OUT_MAX;
         if (shown < SUM_OUT_MIN) shown = SUM_OUT_MIN;
         r.window_sum = shown[SUM_OUT_W-1:0];
         expected_q.push_back(r);
      endfunction

      function void check_result(logic pressed, logic press_edge, logic sample_rejected,
                                 logic signed [SUM_OUT_W-1:0] window_sum);
         press_result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected result item (pressed %b edge %b rej %b sum %0d)",
                        $realtime, pressed, press_edge, sample_rejected, window_sum);
            return;
         end
         want = expected_q.pop_front();
         if (pressed !== want.pressed || press_edge !== want.press_edge ||
             sample_rejected !== want.sample_rejected || window_sum !== want.window_sum) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display({"%0t: mismatch: expected pressed %b edge %b rej %b sum %0d, ",
                         "got pressed %b edge %b rej %b sum %0d"},
                        $realtime, want.pressed, want.press_edge, want.sample_rejected,
                        want.window_sum, pressed, press_edge, sample_rejected, window_sum);
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [SAMPLE_W-1:0]         req_touch_sample;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic                        rsp_pressed;
   logic                        rsp_press_edge;
   logic                        rsp_sample_rejected;
   logic signed [SUM_OUT_W-1:0] rsp_window_sum;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]       csr_data;

   press_scoreboard sb = new();
   int quiet_cycles = 0;
   bit idling_on = 1;
   bit hold_now = 0;
   int touch_plateau = 1000;
   int last_sent = 0;

   touch_button_press_detector_top #(
      .WINDOW(WINDOW_LEN)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_touch_sample(req_touch_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pressed(rsp_pressed),
      .rsp_press_edge(rsp_press_edge),
      .rsp_sample_rejected(rsp_sample_rejected),
      .rsp_window_sum(rsp_window_sum),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Free-running clock.
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Result side: short random stall bursts, and a long hold-off on request.
   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_now) begin
            rsp_stall = 1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 0;
            hold_now  = 0;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_stall = 1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_stall = 0;
         end
      end
   end

   // Note accepted samples, check accepted results and count quiet cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_sample(req_touch_sample);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_pressed, rsp_press_edge, rsp_sample_rejected, rsp_window_sum);
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Watchdog: end the run if nothing moves for too long.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("touch_button_press_detector_top_test: done, errors");
      $finish;
   end

   function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
      if (v < 0) return '0;
      if (v > 65535) return 16'hFFFF;
      return v[SAMPLE_W-1:0];
   endfunction

   // Mostly a walk toward a plateau within the jump limit, so presses build up and
   // release; the rest is deliberate outlier jumps and full-range noise.
   function automatic logic [SAMPLE_W-1:0] next_touch_sample(input int prev, input int lim);
      int roll;
      int reach;
      int diff;
      int mag;
      int v;
      roll = $urandom_range(0, 99);
      if (roll < 6)
         return clamp_sample(int'($urandom_range(0, 65535)));
      if (roll < 12 && lim > 0 && lim < 30000) begin
         mag = lim + int'($urandom_range(0, 300));
         v = ($urandom_range(0, 1) != 0) ? prev + mag : prev - mag;
         if (v > 65535) v = prev - mag;
         if (v < 0) v = prev + mag;
         return clamp_sample(v);
      end
      if ($urandom_range(0, 24) == 0)
         touch_plateau = ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 65535))
                         : int'(clamp_sample(prev + int'($urandom_range(0, 4000)) - 2000));
      reach = (lim > 0) ? lim - 1 : 0;
      diff  = touch_plateau - prev;
      if (diff > reach)
         v = prev + int'($urandom_range(reach / 2, reach));
      else if (-diff > reach)
         v = prev - int'($urandom_range(reach / 2, reach));
      else
         v = touch_plateau + int'($urandom_range(0, 6)) - 3;
      return clamp_sample(v);
   endfunction

   // Offer one sample, with an optional gap before it, and wait until it is taken.
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      @(negedge clock);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid        = 1;
      req_touch_sample = value;
      last_sent        = int'(value);
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Stop offering and wait until every expected result has arrived.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Register write, made only while the block is idle.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      drain_results();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid = 1;
      csr_index = index;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(index, data);
      @(negedge clock);
      csr_valid = 0;
   endtask

   // One random phase under one register setting.
   task automatic run_phase(input logic [THR_W-1:0] thr, input logic [LIMIT_W-1:0] lim,
                            input logic [ALPHA_W-1:0] alpha, input int items,
                            input int hold_at, input int pause_at);
      logic [CSR_DATA_W-1:0] alpha_word;
      alpha_word = CSR_DATA_W'($urandom_range(0, 65535));
      alpha_word[ALPHA_W-1:0] = alpha;
      csr_write(CSR_PRESS_THRESHOLD, thr);
      csr_write(CSR_OUTLIER_LIMIT, lim);
      csr_write(CSR_ALPHA_SHIFT, alpha_word);
      for (int i = 0; i < items; i++) begin
         if (i == hold_at) hold_now = 1;
         if (i == pause_at) drain_results();
         send_sample(next_touch_sample(last_sent, int'(lim)));
      end
   endtask

   initial begin
      reset            = 1;
      req_valid        = 0;
      req_touch_sample = '0;
      csr_valid        = 0;
      csr_index        = CSR_PRESS_THRESHOLD;
      csr_data         = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;
      @(posedge clock);

      // Reset settings: priming, a press with its edge, jumps beyond and at the limit,
      // and a step just inside it.
      send_sample(16'd1000);
      send_sample(16'd1050);
      send_sample(16'd1100);
      send_sample(16'd1150);
      send_sample(16'd1300);
      send_sample(16'd1200);
      send_sample(16'd1199);
      send_sample(16'd1100);

      // No smoothing, top limit, zero threshold: full-scale swings, which still reach the limit.
      csr_write(CSR_PRESS_THRESHOLD, 16'h0000);
      csr_write(CSR_OUTLIER_LIMIT, 16'hFFFF);
      csr_write(CSR_ALPHA_SHIFT, 16'hFFF0);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'h0000);

      // Slowest smoothing, top threshold: jumps at the limit and one huge negative deviation.
      csr_write(CSR_ALPHA_SHIFT, 16'h000F);
      csr_write(CSR_PRESS_THRESHOLD, 16'hFFFF);
      send_sample(16'hFFFF);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      send_sample(16'h0000);
      send_sample(16'hFFFF);

      // A write to an unmapped index changes nothing; a zero limit rejects everything.
      csr_write(CSR_UNMAPPED, 16'hFFFF);
      csr_write(CSR_OUTLIER_LIMIT, 16'h0000);
      send_sample(16'd7);
      send_sample(16'd7);

      // Random phases across register settings.
      run_phase(THRESHOLD_RESET, LIMIT_RESET, ALPHA_RESET, 90, -1, -1);
      run_phase(THR_W'($urandom_range(0, 300)), LIMIT_W'($urandom_range(50, 3000)),
                ALPHA_W'($urandom_range(0, 15)), 90, 40, -1);
      run_phase(16'h0000, 16'hFFFF, 4'd0, 70, -1, -1);
      run_phase(16'hFFFF, 16'hFFFF, 4'd15, 80, -1, 30);
      run_phase(THR_W'($urandom_range(0, 65535)), LIMIT_W'($urandom_range(0, 65535)),
                ALPHA_W'($urandom_range(0, 15)), 90, 20, 60);
      idling_on = 0;
      run_phase(THR_W'($urandom_range(0, 40)), LIMIT_W'($urandom_range(100, 1000)),
                ALPHA_W'($urandom_range(4, 12)), 80, -1, -1);

      drain_results();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("touch_button_press_detector_top_test: done, clean");
      else
         $display("touch_button_press_detector_top_test: done, errors");
      $finish;
   end

endmodule

### files.f
hw/rtl/tbpd_pkg.sv
hw/rtl/tbpd_ram.sv
hw/rtl/tbpd_track.sv
hw/rtl/touch_button_press_detector_top.sv
sim/touch_button_press_detector_top_test.sv
